// ===== rtl/tbs_pkg.sv =====
package tbs_pkg;

   localparam int TIMER_COUNT_DEFAULT = 16;

   localparam int SLOT_W   = 6;
   localparam int PERIOD_W = 24;
   localparam int LEFT_W   = 26;
   localparam int MS_W     = 16;

   localparam logic [MS_W-1:0] CEILING_RESET = 16'd1000;

   // request codes
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_CREATE  = 2'd1;
   localparam logic [1:0] REQ_DESTROY = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // slot kinds
   localparam logic [1:0] KIND_FREE     = 2'd0;
   localparam logic [1:0] KIND_ONESHOT  = 2'd1;
   localparam logic [1:0] KIND_PERIODIC = 2'd2;

   // lowest time left value, -2^25
   localparam logic [LEFT_W-1:0] LEFT_MIN = {1'b1, {(LEFT_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]          req_type;
      logic [MS_W-1:0]     elapsed_ms;
      logic                timer_kind;
      logic [PERIOD_W-1:0] period;
      logic [SLOT_W-1:0]   slot;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              fired;
      logic [SLOT_W-1:0] fired_slot;
      logic [SLOT_W-1:0] created_slot;
      logic [MS_W-1:0]   wait_ms;
   } rsp_payload_type;

   // token walking down the cell row
   typedef struct packed {
      logic                     active;
      logic [1:0]               req_type;
      logic [MS_W-1:0]          elapsed_ms;
      logic                     timer_kind;
      logic [PERIOD_W-1:0]      period;
      logic [SLOT_W-1:0]        slot;
      logic                     hit;      // tick: minimum seen, create: free slot claimed
      logic signed [LEFT_W-1:0] best_val;
      logic [SLOT_W-1:0]        hit_idx;
   } token_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] idx;
   } fire_type;

endpackage

// ===== rtl/tbs_cell.sv =====
module tbs_cell
   import tbs_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type token_in,
   output token_type token_out,
   input  fire_type  fire
);

   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_INDEX);

   logic [1:0]          kind_ff, kind_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   token_type           token_ff, token_in_nxt;

   logic [LEFT_W:0]     diff;
   logic [LEFT_W-1:0]   sat;

   // time left minus elapsed, clamped at the lowest value
   assign diff = {left_ff[LEFT_W-1], left_ff} - {{(LEFT_W+1-MS_W){1'b0}}, token_in.elapsed_ms};
   assign sat  = (diff[LEFT_W] != diff[LEFT_W-1]) ? LEFT_MIN : diff[LEFT_W-1:0];

   always_comb begin
      kind_in      = kind_ff;
      period_in    = period_ff;
      left_in      = left_ff;
      token_in_nxt = token_in;
      if (token_in.active) begin
         case (token_in.req_type)
            REQ_TICK: begin
               if (kind_ff != KIND_FREE) begin
                  left_in = sat;
                  if (!token_in.hit || ($signed(sat) < token_in.best_val)) begin
                     token_in_nxt.hit      = 1'b1;
                     token_in_nxt.best_val = $signed(sat);
                     token_in_nxt.hit_idx  = MY_IDX;
                  end
               end
            end
            REQ_CREATE: begin
               if (!token_in.hit && (kind_ff == KIND_FREE)) begin
                  kind_in              = token_in.timer_kind ? KIND_PERIODIC : KIND_ONESHOT;
                  period_in            = token_in.period;
                  left_in              = {{(LEFT_W-PERIOD_W){1'b0}}, token_in.period};
                  token_in_nxt.hit     = 1'b1;
                  token_in_nxt.hit_idx = MY_IDX;
               end
            end
            REQ_DESTROY: begin
               if (token_in.slot == MY_IDX) begin
                  kind_in = KIND_FREE;
               end
            end
            default: begin
            end
         endcase
      end
      // serve an overdue slot: reload, and free a one-shot
      if (fire.valid && (fire.idx == MY_IDX)) begin
         left_in = {{(LEFT_W-PERIOD_W){1'b0}}, period_ff};
         if (kind_ff == KIND_ONESHOT) begin
            kind_in = KIND_FREE;
         end
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      left_ff   <= left_in;
      if (reset) begin
         kind_ff         <= KIND_FREE;
         token_ff.active <= 1'b0;
      end else begin
         kind_ff  <= kind_in;
         token_ff <= token_in_nxt;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== rtl/tbs_ctrl.sv =====
module tbs_ctrl
   import tbs_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [MS_W-1:0] csr_data,
   output token_type       launch,
   input  token_type       ret,
   output fire_type        fire
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            rsp_valid_ff, rsp_valid_in;
   token_type       launch_ff, launch_in;
   fire_type        fire_ff, fire_in;
   rsp_payload_type hold_ff, res;
   rsp_payload_type rsp_ff;
   logic [MS_W-1:0] ceiling_ff;
   logic            req_take;
   logic            load;
   logic            overdue;

   assign req_take = req_valid && !busy_ff;
   assign load     = done_ff && (!rsp_valid_ff || !rsp_stall);
   assign overdue  = ret.hit && ret.best_val[LEFT_W-1];

   always_comb begin
      busy_in = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end

      done_in = done_ff;
      if (ret.active) begin
         done_in = 1'b1;
      end else if (load) begin
         done_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      launch_in            = launch_ff;
      launch_in.active     = req_take;
      if (req_take) begin
         launch_in.req_type   = req_data.req_type;
         launch_in.elapsed_ms = req_data.elapsed_ms;
         launch_in.timer_kind = req_data.timer_kind;
         launch_in.period     = req_data.period;
         launch_in.slot       = req_data.slot;
         launch_in.hit        = 1'b0;
         launch_in.best_val   = '0;
         launch_in.hit_idx    = '0;
      end

      fire_in.valid = ret.active && (ret.req_type == REQ_TICK) && overdue;
      fire_in.idx   = ret.hit_idx;

      res = '0;
      case (ret.req_type)
         REQ_TICK: begin
            if (overdue) begin
               res.fired      = 1'b1;
               res.fired_slot = ret.hit_idx;
            end else if (ret.hit && (ret.best_val != '0) &&
                         ($unsigned(ret.best_val) < {{(LEFT_W-MS_W){1'b0}}, ceiling_ff})) begin
               res.wait_ms = ret.best_val[MS_W-1:0];
            end else begin
               res.wait_ms = ceiling_ff;
            end
         end
         REQ_CREATE: begin
            if (ret.hit) begin
               res.created_slot = ret.hit_idx;
            end else begin
               res.status = ST_FULL;
            end
         end
         REQ_DESTROY: begin
            if ({1'b0, ret.slot} >= (SLOT_W+1)'(TIMER_COUNT)) begin
               res.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ret.active) begin
         hold_ff <= res;
      end
      if (load) begin
         rsp_ff <= hold_ff;
      end
      fire_ff.idx <= fire_in.idx;
      if (reset) begin
         busy_ff          <= 1'b0;
         done_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         launch_ff.active <= 1'b0;
         fire_ff.valid    <= 1'b0;
         ceiling_ff       <= CEILING_RESET;
      end else begin
         busy_ff       <= busy_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         launch_ff     <= launch_in;
         fire_ff.valid <= fire_in.valid;
         if (csr_valid && csr_ready) begin
            ceiling_ff <= csr_data;
         end
      end
   end

   assign req_stall = busy_ff;
   assign csr_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign launch    = launch_ff;
   assign fire      = fire_ff;

`ifndef SYNTHESIS
   a_done_in_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> busy_ff)
      else $error("held result outside a busy period");

   a_ret_in_walk: assert property (@(posedge clock) disable iff (reset)
      ret.active |-> (busy_ff && !done_ff))
      else $error("token returned with no walk in flight");

   a_fire_matches_result: assert property (@(posedge clock) disable iff (reset)
      fire_ff.valid |-> (hold_ff.fired && (hold_ff.wait_ms == '0) &&
                         (hold_ff.fired_slot == fire_ff.idx)))
      else $error("fire pulse disagrees with the held result");

   a_take_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (busy_ff && launch_ff.active))
      else $error("accepted request did not launch a walk");
`endif

endmodule

// ===== rtl/timer_bank_scheduler.sv =====
// a request is registered into the launch token, walks the slot cells, and its result is held
// until the output register is free; a new request is taken only once that result is loaded
// a finished result may wait in the output register while the next request is walked
// reset (synchronous, active high): every slot free, ceiling back to 1000, no result pending
module timer_bank_scheduler
   import tbs_pkg::*;
#(
   parameter int TIMER_COUNT = TIMER_COUNT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   // ceiling register write
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [MS_W-1:0] csr_data
);

   // token path: entry 0 is fed by the controller, the last entry returns to it
   token_type chain [TIMER_COUNT+1];
   fire_type  fire;

   // controller: takes one request at a time, launches a token, turns the
   // returning token into a result and, for an overdue tick, the fire pulse
   tbs_ctrl #(
      .TIMER_COUNT(TIMER_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .launch    (chain[0]),
      .ret       (chain[TIMER_COUNT]),
      .fire      (fire)
   );

   // row of slot cells; each holds one slot and passes the token on through its own register
   //  tick:    subtract elapsed time, carry the first minimum along
   //  create:  first free cell claims the slot and marks the token
   //  destroy: the addressed cell frees itself
   // the fire pulse lands the cycle after the token returns, before any new
   // token can reach the row
   for (genvar gi = 0; gi < TIMER_COUNT; gi++) begin : g_cell
      tbs_cell #(
         .CELL_INDEX(gi)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .token_in  (chain[gi]),
         .token_out (chain[gi+1]),
         .fire      (fire)
      );
   end

endmodule
